// ===== src/obf_pkg.sv =====
// Shared constants, types and codes for the order book top-of-book block.
`timescale 1ns / 1ps
package obf_pkg;

  localparam int LEVELS = 64;
  localparam int LVL_W = $clog2(LEVELS);
  localparam int CNT_W = LVL_W + 1;

  localparam int SYM_W = 16;
  localparam int PRICE_W = 32;
  localparam int QTY_W = 32;
  localparam int TIME_W = 48;
  localparam int STAT_W = 3;
  localparam int COUNT_W = 32;

  localparam int MID_W = PRICE_W + 1;
  localparam int PCT_W = 25;
  localparam int FRAC_W = 16;
  localparam int MICRO_W = 48;

  localparam int PCT_SCALE = 13107200;
  localparam int PCT_SCALE_W = 24;
  localparam int PCT_PROD_W = PRICE_W + PCT_SCALE_W;
  localparam int MP_PROD_W = PRICE_W + QTY_W;

  localparam int DIV_NUM_W = MP_PROD_W + FRAC_W;
  localparam int DIV_DEN_W = QTY_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_BOOK_SYMBOL = 1'b0;

  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_FILL = 1'b1;
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_SYM_MISMATCH = 3'd1,
    ST_PRICE_ABSENT = 3'd2,
    ST_OVERFILL     = 3'd3,
    ST_SIDE_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_UPDATE,
    S_BEST,
    S_MUL,
    S_PCT_START,
    S_PCT_WAIT,
    S_MP_START,
    S_MP_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } lvl_entry_t;

  typedef struct packed {
    logic               en;
    logic               vset;
    logic               vclr;
    logic               side;
    logic [LVL_W-1:0]   addr;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } lvl_wr_t;

endpackage

// ===== src/order_book_fill_top_of_book.sv =====
// Top level: order book sequencer, quote metrics and configuration port.
// An item makes up to two sweeps of the level memories and up to two serial
//   divisions.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: synchronous; clears all levels (valid bits), count, time and symbol.
// The result is flagged for one cycle on done; the receiver cannot stall it.
`timescale 1ns / 1ps
module order_book_fill_top_of_book
  import obf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action,
  input  logic [SYM_W-1:0]      symbol_id,
  input  logic                  side,
  input  logic [PRICE_W-1:0]    price,
  input  logic [QTY_W-1:0]      quantity,
  input  logic [TIME_W-1:0]     event_time,
  output logic                  done,
  output logic [STAT_W-1:0]     status,
  output logic [PRICE_W-1:0]    best_bid_price,
  output logic [QTY_W-1:0]      best_bid_qty,
  output logic [PRICE_W-1:0]    best_ask_price,
  output logic [QTY_W-1:0]      best_ask_qty,
  output logic [MID_W-1:0]      mid_half_ticks,
  output logic [MID_W-1:0]      spread_ticks,
  output logic [PCT_W-1:0]      spread_pct_q16,
  output logic [MICRO_W-1:0]    microprice_q16,
  output logic [COUNT_W-1:0]    update_count,
  output logic [TIME_W-1:0]     last_time
);

  // Configuration register: one word, symbol in the low bits.
  logic [SYM_W-1:0] book_symbol;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BOOK_SYMBOL) ? APB_DATA_W'(book_symbol) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      book_symbol <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_BOOK_SYMBOL) begin
      book_symbol <= pwdata[SYM_W-1:0];
    end
  end

  state_t state, state_next;
  logic accept;
  assign busy = (state != S_IDLE);
  assign accept = start && !busy;

  // Latched item.
  logic               act_q;
  logic               side_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;
  logic [TIME_W-1:0]  event_time_q;
  logic               tgt;

  // target side: a buy fill hits the asks, a sell fill the bids
  assign tgt = (act_q == ACT_FILL) ? ~side_q : side_q;

  // Sweep control: address issued now, data in the cycle after.
  logic [CNT_W-1:0] cnt;
  logic             dv;
  logic [LVL_W-1:0] didx;
  logic             issue;
  logic             sweep_end;
  assign issue = (state == S_FIND || state == S_BEST) && (cnt < CNT_W'(LEVELS));
  assign sweep_end = (cnt == CNT_W'(LEVELS)) && !dv;

  lvl_entry_t bid_rd, ask_rd, tgt_rd;
  lvl_wr_t    wr;
  assign tgt_rd = (tgt == SIDE_ASK) ? ask_rd : bid_rd;

  obf_levels u_levels (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (cnt[LVL_W-1:0]),
    .wr      (wr),
    .bid_rd  (bid_rd),
    .ask_rd  (ask_rd)
  );

  // Search results on the target side.
  logic             found;
  logic [LVL_W-1:0] midx;
  logic [QTY_W-1:0] mqty;
  logic             free_found;
  logic [LVL_W-1:0] fidx;

  // Book state and best levels.
  status_t            status_r;
  logic [COUNT_W-1:0] fill_counter;
  logic [TIME_W-1:0]  stored_time;
  logic [PRICE_W-1:0] bp, ap;
  logic [QTY_W-1:0]   bv, av;
  logic               bfound, afound;

  // Quote metrics.
  logic                 both_px;
  logic                 neg;
  logic [PRICE_W-1:0]   mag;
  logic [MID_W-1:0]     mid33;
  logic [PRICE_W-1:0]   mp_lo;
  logic [QTY_W-1:0]     mp_w;
  logic [DIV_DEN_W-1:0] mp_d;
  logic                 mp_bid_empty, mp_ask_empty;
  logic [PCT_PROD_W-1:0] prod_pct;
  logic [MP_PROD_W-1:0]  prod_mp;
  logic [PCT_W-1:0]      pct_q;
  logic [MICRO_W-1:0]    micro_q;

  assign both_px = (bp != '0) && (ap != '0);
  assign neg = ap < bp;
  assign mag = neg ? (bp - ap) : (ap - bp);
  assign mid33 = {1'b0, bp} + {1'b0, ap};
  assign mp_lo = neg ? ap : bp;
  assign mp_w = neg ? av : bv;
  assign mp_d = {1'b0, bv} + {1'b0, av};
  assign mp_bid_empty = (bp == '0) || (bv == '0);
  assign mp_ask_empty = (ap == '0) || (av == '0);

  // Shared divider: percent spread first, then microprice.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  always_comb begin
    if (state == S_PCT_START) begin
      div_num = DIV_NUM_W'(prod_pct) + DIV_NUM_W'(mid33 >> 1);
      div_den = DIV_DEN_W'(mid33);
    end else begin
      div_num = {prod_mp, {FRAC_W{1'b0}}} + DIV_NUM_W'(mp_d >> 1);
      div_den = mp_d;
    end
  end

  obf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = (symbol_id == book_symbol) ? S_FIND : S_BEST;
      end
      S_FIND:      if (sweep_end) state_next = S_UPDATE;
      S_UPDATE:    state_next = S_BEST;
      S_BEST:      if (sweep_end) state_next = S_MUL;
      S_MUL:       state_next = S_PCT_START;
      S_PCT_START: state_next = both_px ? S_PCT_WAIT : S_MP_START;
      S_PCT_WAIT:  if (div_done) state_next = S_MP_START;
      S_MP_START:  state_next = (mp_bid_empty || mp_ask_empty) ? S_DONE : S_MP_WAIT;
      S_MP_WAIT:   if (div_done) state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control outputs: divider start and level write.
  always_comb begin
    div_start = 1'b0;
    wr = '0;
    wr.side = tgt;
    wr.price = price_q;
    case (state)
      S_PCT_START: div_start = both_px;
      S_MP_START:  div_start = !(mp_bid_empty || mp_ask_empty);
      S_UPDATE: begin
        if (act_q == ACT_SET) begin
          if (found) begin
            wr.addr = midx;
            wr.qty = qty_q;
            if (qty_q == '0) wr.vclr = 1'b1;
            else wr.en = 1'b1;
          end else if (qty_q != '0 && free_found) begin
            wr.addr = fidx;
            wr.qty = qty_q;
            wr.en = 1'b1;
            wr.vset = 1'b1;
          end
        end else if (found && qty_q <= mqty) begin
          wr.addr = midx;
          wr.qty = mqty - qty_q;
          if (qty_q == mqty) wr.vclr = 1'b1;
          else wr.en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      dv <= 1'b0;
      done <= 1'b0;
      fill_counter <= '0;
      stored_time <= '0;
    end else begin
      state <= state_next;
      done <= (state == S_DONE);
      dv <= issue;
      if (issue) cnt <= cnt + 1'b1;
      else if (sweep_end) cnt <= '0;
      if (state == S_UPDATE && act_q == ACT_FILL) begin
        fill_counter <= fill_counter + 1'b1;
        stored_time <= event_time_q;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    didx <= cnt[LVL_W-1:0];
    if (accept) begin
      act_q <= action;
      side_q <= side;
      price_q <= price;
      qty_q <= quantity;
      event_time_q <= event_time;
      status_r <= (symbol_id == book_symbol) ? ST_OK : ST_SYM_MISMATCH;
      found <= 1'b0;
      free_found <= 1'b0;
      midx <= '0;
      fidx <= '0;
      mqty <= '0;
      bfound <= 1'b0;
      afound <= 1'b0;
      bp <= '0;
      bv <= '0;
      ap <= '0;
      av <= '0;
    end
    // first matching valid level, first free slot
    if (state == S_FIND && dv) begin
      if (tgt_rd.valid && tgt_rd.price == price_q && !found) begin
        found <= 1'b1;
        midx <= didx;
        mqty <= tgt_rd.qty;
      end
      if (!tgt_rd.valid && !free_found) begin
        free_found <= 1'b1;
        fidx <= didx;
      end
    end
    if (state == S_UPDATE) begin
      if (act_q == ACT_SET) begin
        if (!found && qty_q != '0 && !free_found) status_r <= ST_SIDE_FULL;
      end else if (!found) begin
        status_r <= ST_PRICE_ABSENT;
      end else if (qty_q > mqty) begin
        status_r <= ST_OVERFILL;
      end
    end
    // highest bid, lowest ask; first one wins on a tie
    if (state == S_BEST && dv) begin
      if (bid_rd.valid && (!bfound || bid_rd.price > bp)) begin
        bfound <= 1'b1;
        bp <= bid_rd.price;
        bv <= bid_rd.qty;
      end
      if (ask_rd.valid && (!afound || ask_rd.price < ap)) begin
        afound <= 1'b1;
        ap <= ask_rd.price;
        av <= ask_rd.qty;
      end
    end
    if (state == S_MUL) begin
      prod_pct <= PCT_PROD_W'(mag) * PCT_PROD_W'(PCT_SCALE);
      prod_mp <= MP_PROD_W'(mp_w) * MP_PROD_W'(mag);
    end
    if (state == S_PCT_START && !both_px) pct_q <= '0;
    if (state == S_PCT_WAIT && div_done) begin
      pct_q <= neg ? PCT_W'(0 - div_quo[PCT_W-1:0]) : div_quo[PCT_W-1:0];
    end
    if (state == S_MP_START) begin
      if (mp_bid_empty) micro_q <= {ap, {FRAC_W{1'b0}}};
      else if (mp_ask_empty) micro_q <= {bp, {FRAC_W{1'b0}}};
    end
    if (state == S_MP_WAIT && div_done) begin
      micro_q <= {mp_lo, {FRAC_W{1'b0}}} + div_quo[MICRO_W-1:0];
    end
    // hold the result until the next item finishes
    if (state == S_DONE) begin
      status <= status_r;
      best_bid_price <= bp;
      best_bid_qty <= bv;
      best_ask_price <= ap;
      best_ask_qty <= av;
      mid_half_ticks <= both_px ? mid33 : '0;
      spread_ticks <= both_px ? ({1'b0, ap} - {1'b0, bp}) : '0;
      spread_pct_q16 <= pct_q;
      microprice_q16 <= micro_q;
      update_count <= fill_counter;
      last_time <= stored_time;
    end
  end

endmodule

// ===== src/obf_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module obf_div
  import obf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] rem_next;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   sh;
  logic                 qbit;

  always_comb begin
    sh = {rem, quo[DIV_NUM_W-1]};
    if (sh >= {1'b0, den_q}) begin
      qbit = 1'b1;
      rem_next = DIV_DEN_W'(sh - {1'b0, den_q});
    end else begin
      qbit = 1'b0;
      rem_next = sh[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIV_NUM_W-2:0], qbit};
    end
  end

endmodule

// ===== src/obf_levels.sv =====
// Bid and ask level memories with per-entry valid bits.
`timescale 1ns / 1ps
module obf_levels
  import obf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [LVL_W-1:0] rd_addr,
  input  lvl_wr_t          wr,
  output lvl_entry_t       bid_rd,
  output lvl_entry_t       ask_rd
);

  logic [PRICE_W+QTY_W-1:0] bid_mem [LEVELS];
  logic [PRICE_W+QTY_W-1:0] ask_mem [LEVELS];
  logic [LEVELS-1:0]        bid_vld;
  logic [LEVELS-1:0]        ask_vld;

  always_ff @(posedge clk) begin
    if (wr.en && wr.side == SIDE_BID) begin
      bid_mem[wr.addr] <= {wr.price, wr.qty};
    end
    if (wr.en && wr.side == SIDE_ASK) begin
      ask_mem[wr.addr] <= {wr.price, wr.qty};
    end
    bid_rd <= {bid_vld[rd_addr], bid_mem[rd_addr]};
    ask_rd <= {ask_vld[rd_addr], ask_mem[rd_addr]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_vld <= '0;
      ask_vld <= '0;
    end else begin
      if (wr.side == SIDE_BID) begin
        if (wr.vset) bid_vld[wr.addr] <= 1'b1;
        if (wr.vclr) bid_vld[wr.addr] <= 1'b0;
      end else begin
        if (wr.vset) ask_vld[wr.addr] <= 1'b1;
        if (wr.vclr) ask_vld[wr.addr] <= 1'b0;
      end
    end
  end

endmodule
